// ----- rtl/core/bpq_pkg.sv -----
// ----------------------------------------------------------------------------
// bpq_pkg: shared types and constants of the bucket priority queue
// Sizes, link encoding, status and operation codes, sequencer states.
// ----------------------------------------------------------------------------
package bpq_pkg;
  localparam int NUM_ELEMENTS = 1024;
  localparam int NUM_BUCKETS  = 1024;
  localparam int EW = $clog2(NUM_ELEMENTS);
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int LW = EW + 1;
  localparam int KW = 10;
  localparam int IDW = 10;
  localparam int NUM_CLEAR = (NUM_ELEMENTS > NUM_BUCKETS) ? NUM_ELEMENTS : NUM_BUCKETS;
  localparam int CW = $clog2(NUM_CLEAR);

  typedef logic [LW-1:0] link_t;
  localparam link_t NIL = {LW{1'b1}};

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_UPDATE = 3'd2,
    OP_DEC    = 3'd3,
    OP_MIN    = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_RANGE    = 2'd2,
    ST_CONFLICT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHECK, S_UNL_RD, S_UNL_WR, S_LNK_RD, S_LNK_WR,
    S_SCAN_RD, S_SCAN_CHK, S_CLEAR, S_DONE, S_INIT
  } state_t;

  // bucket memory port request
  typedef struct packed {
    logic          we;
    logic [BW-1:0] addr;
    link_t         wdata;
  } bkt_req_t;
endpackage

// ----- rtl/core/bucket_priority_queue.sv -----
// ----------------------------------------------------------------------------
// bucket_priority_queue: bucket queue over element ids with small keys
// Each word runs under one sequencer sharing the link and bucket memories.
// Each memory has a single registered read port. Select min reads and checks
// each bucket in turn from the low bound, and skips the scan when the bounds
// already show an empty queue. Clear runs a write pass over the bucket heads
// and presence bits. The same pass runs after reset before the first word is
// taken. A stalled result holds the sequencer until it is taken.
// ----------------------------------------------------------------------------
module bucket_priority_queue
  import bpq_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [KW-1:0]  cfg_wdata,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [2:0]     in_op,
  input  logic [IDW-1:0] in_element_id,
  input  logic [KW-1:0]  in_key,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_status,
  output logic [IDW-1:0] out_min_element,
  output logic [KW-1:0]  out_min_key
);
  state_t state_r, state_nxt;
  logic [KW-1:0] max_key_r;
  logic [2:0] op_r;
  logic [EW-1:0] e_r;
  logic [KW-1:0] k_r, tk_r;
  logic [KW:0] low_r, low_nxt;
  logic [KW-1:0] high_r, high_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  link_t p_r, n_r;
  logic pr_r;
  logic [KW-1:0] ok_r;
  logic [1:0] st_r, st_nxt;
  logic [IDW-1:0] me_r, me_nxt;
  logic [KW-1:0] mk_r, mk_nxt;
  logic ld_cur;

  // element link memories
  link_t prv_m [NUM_ELEMENTS];
  link_t nxt_m [NUM_ELEMENTS];
  logic [KW-1:0] key_m [NUM_ELEMENTS];
  logic pres_m [NUM_ELEMENTS];
  logic [EW-1:0] er_addr;
  link_t prv_q, nxt_q;
  logic [KW-1:0] key_q;
  logic pres_q;
  logic pw_en, nw_en, kw_en, pr_we;
  logic [EW-1:0] pw_addr, nw_addr, pr_waddr;
  link_t pw_data, nw_data;
  logic pr_wdata;

  always_ff @(posedge clk) begin
    if (pw_en) prv_m[pw_addr] <= pw_data;
    if (nw_en) nxt_m[nw_addr] <= nw_data;
    if (kw_en) key_m[e_r] <= tk_r;
    if (pr_we) pres_m[pr_waddr] <= pr_wdata;
    prv_q <= prv_m[er_addr];
    nxt_q <= nxt_m[er_addr];
    key_q <= key_m[er_addr];
    pres_q <= pres_m[er_addr];
  end

  bkt_req_t breq;
  link_t brd;
  bpq_bucket_ram u_bkt (.clk(clk), .req(breq), .rdata(brd));

  function automatic logic key_ok(input logic [KW-1:0] k, input logic [KW-1:0] mk);
    return (k <= mk) && ({1'b0, k} < (KW+1)'(NUM_BUCKETS));
  endfunction

  logic in_acc;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_valid = (state_r == S_DONE);
  assign out_status = st_r;
  assign out_min_element = me_r;
  assign out_min_key = mk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      max_key_r <= {KW{1'b1}};
      low_r <= {1'b0, {KW{1'b1}}};
      high_r <= '0;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) max_key_r <= cfg_wdata;
      low_r <= low_nxt;
      high_r <= high_nxt;
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_op;
      e_r <= in_element_id[EW-1:0];
      k_r <= in_key;
    end
    if (ld_cur) begin
      p_r <= prv_q;
      n_r <= nxt_q;
      ok_r <= key_q;
      pr_r <= pres_q;
    end
    st_r <= st_nxt;
    me_r <= me_nxt;
    mk_r <= mk_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    low_nxt = low_r;
    high_nxt = high_r;
    clr_nxt = clr_r;
    st_nxt = st_r;
    me_nxt = me_r;
    mk_nxt = mk_r;
    ld_cur = 1'b0;
    er_addr = e_r;
    pw_en = 1'b0; pw_addr = e_r; pw_data = NIL;
    nw_en = 1'b0; nw_addr = e_r; nw_data = NIL;
    kw_en = 1'b0;
    pr_we = 1'b0; pr_waddr = e_r; pr_wdata = 1'b0;
    breq = '{we: 1'b0, addr: low_r[BW-1:0], wdata: NIL};
    case (state_r)
      S_IDLE: begin
        er_addr = in_element_id[EW-1:0];
        if (in_acc) begin
          st_nxt = ST_OK; me_nxt = '0; mk_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ld_cur = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        case (op_r)
          OP_INSERT: begin
            if (pr_r) begin st_nxt = ST_CONFLICT; state_nxt = S_DONE; end
            else if (!key_ok(k_r, max_key_r)) begin st_nxt = ST_RANGE; state_nxt = S_DONE; end
            else state_nxt = S_LNK_RD;
          end
          OP_REMOVE: begin
            if (!pr_r) begin st_nxt = ST_CONFLICT; state_nxt = S_DONE; end
            else state_nxt = S_UNL_RD;
          end
          OP_UPDATE: begin
            if (!pr_r) begin st_nxt = ST_CONFLICT; state_nxt = S_DONE; end
            else if (!key_ok(k_r, max_key_r)) begin st_nxt = ST_RANGE; state_nxt = S_DONE; end
            else state_nxt = S_UNL_RD;
          end
          OP_DEC: begin
            if (!pr_r) begin st_nxt = ST_CONFLICT; state_nxt = S_DONE; end
            else if (ok_r == '0 || !key_ok(ok_r - 1'b1, max_key_r)) begin
              st_nxt = ST_RANGE; state_nxt = S_DONE;
            end else state_nxt = S_UNL_RD;
          end
          OP_MIN: begin
            breq.addr = low_r[BW-1:0];
            state_nxt = S_SCAN_RD;
            if (low_r > {1'b0, high_r}) begin st_nxt = ST_EMPTY; state_nxt = S_DONE; end
          end
          OP_CLEAR: state_nxt = S_CLEAR;
          default: state_nxt = S_DONE;
        endcase
      end
      S_UNL_RD: begin
        breq.addr = ok_r[BW-1:0];
        state_nxt = S_UNL_WR;
      end
      S_UNL_WR: begin
        if (p_r == NIL) begin
          breq = '{we: 1'b1, addr: ok_r[BW-1:0], wdata: n_r};
        end else begin
          nw_en = 1'b1; nw_addr = p_r[EW-1:0]; nw_data = n_r;
        end
        if (n_r != NIL) begin
          pw_en = 1'b1; pw_addr = n_r[EW-1:0]; pw_data = p_r;
        end
        pr_we = 1'b1; pr_wdata = 1'b0;
        if (op_r == OP_REMOVE) state_nxt = S_DONE;
        else state_nxt = S_LNK_RD;
      end
      S_LNK_RD: begin
        breq.addr = tk_r[BW-1:0];
        pw_en = 1'b1; pw_addr = e_r; pw_data = NIL;
        state_nxt = S_LNK_WR;
      end
      S_LNK_WR: begin
        breq = '{we: 1'b1, addr: tk_r[BW-1:0], wdata: {1'b0, e_r}};
        kw_en = 1'b1;
        nw_en = 1'b1; nw_addr = e_r; nw_data = brd;
        if (brd != NIL) begin
          pw_en = 1'b1; pw_addr = brd[EW-1:0]; pw_data = {1'b0, e_r};
        end
        pr_we = 1'b1; pr_wdata = 1'b1;
        if ({1'b0, tk_r} < low_r) low_nxt = {1'b0, tk_r};
        if (tk_r > high_r) high_nxt = tk_r;
        state_nxt = S_DONE;
      end
      S_SCAN_RD: begin
        breq.addr = low_r[BW-1:0];
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (brd != NIL) begin
          me_nxt = brd[IDW-1:0];
          mk_nxt = low_r[KW-1:0];
          state_nxt = S_DONE;
        end else begin
          low_nxt = low_r + 1'b1;
          if (low_r + 1'b1 > {1'b0, high_r}) begin st_nxt = ST_EMPTY; state_nxt = S_DONE; end
          else state_nxt = S_SCAN_RD;
        end
      end
      S_INIT, S_CLEAR: begin
        breq = '{we: 1'b1, addr: clr_r[BW-1:0], wdata: NIL};
        pr_we = 1'b1; pr_waddr = clr_r[EW-1:0]; pr_wdata = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CW'(NUM_CLEAR - 1)) begin
          clr_nxt = '0;
          if (state_r == S_CLEAR) begin
            low_nxt = {1'b0, max_key_r};
            high_nxt = '0;
            state_nxt = S_DONE;
          end else state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // target key for linking: insert and update use the input key, decrease uses key - 1
  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      tk_r <= (op_r == OP_DEC) ? ok_r - 1'b1 : k_r;
    end
  end

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status))) else $error("result lost");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
`endif
endmodule

// ----- rtl/core/bpq_bucket_ram.sv -----
// ----------------------------------------------------------------------------
// bpq_bucket_ram: bucket head store
// One port, registered read; emptied by a write pass from the sequencer.
// ----------------------------------------------------------------------------
module bpq_bucket_ram
  import bpq_pkg::*;
(
  input  logic     clk,
  input  bkt_req_t req,
  output link_t    rdata
);
  link_t mem [NUM_BUCKETS];
  link_t rd_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_r <= mem[req.addr];
  end

  assign rdata = rd_r;
endmodule
